### sv/sltpt_pkg.sv
// ----------------------------------------------------------------------------
// sltpt_pkg
// Shared constants and types for the sorted line table with packed text.
// ----------------------------------------------------------------------------
`default_nettype none

package sltpt_pkg;

   localparam int MAX_LINES_DEF    = 1024;
   localparam int STORE_BYTES_DEF  = 16384;
   localparam int MAX_LINE_LEN_DEF = 256;

   localparam logic [1:0] REQ_CHAR   = 2'd0;
   localparam logic [1:0] REQ_COMMIT = 2'd1;
   localparam logic [1:0] REQ_FIND   = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_LONG   = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL = 3'd2;
   localparam logic [2:0] ST_STORE_FULL = 3'd3;
   localparam logic [2:0] ST_RESERVED   = 3'd4;

   localparam logic [15:0] RESERVED_NUMBER = 16'hFFFF;
   localparam logic [7:0]  CH_NUL   = 8'h00;
   localparam logic [7:0]  CH_ZERO  = 8'h30;
   localparam logic [7:0]  CH_NINE  = 8'h39;
   localparam logic [7:0]  CH_SPACE = 8'h20;

   localparam int LEN_W = 11;

   typedef struct packed {
      logic [15:0]      number;
      logic [LEN_W-1:0] length;
      logic             too_long;
   } pend_info_type;

endpackage

`default_nettype wire

### sv/sltpt_text_mem.sv
// ----------------------------------------------------------------------------
// sltpt_text_mem
// Byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sltpt_text_mem #(
   parameter int DEPTH = sltpt_pkg::STORE_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [7:0]               wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [7:0]               rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/sltpt_line_buf.sv
// ----------------------------------------------------------------------------
// sltpt_line_buf
// Parses typed characters into a line number and buffers the line text.
// ----------------------------------------------------------------------------
`default_nettype none

module sltpt_line_buf #(
   parameter int MAX_LINE_LEN = sltpt_pkg::MAX_LINE_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            char_we,
   input  wire logic [7:0]                      ch,
   input  wire logic                            clear,
   input  wire logic [$clog2(MAX_LINE_LEN)-1:0] rd_addr,
   output logic      [7:0]                      rd_data,
   output sltpt_pkg::pend_info_type             info,
   output logic                                 reject
);

   localparam int LAW = $clog2(MAX_LINE_LEN);
   localparam int LW  = $clog2(MAX_LINE_LEN + 1);

   typedef enum logic [2:0] {
      PH_DIGITS = 3'b001,
      PH_SKIP   = 3'b010,
      PH_TEXT   = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] num_ff, num_in;
   logic [LW-1:0] len_ff, len_in;
   logic        long_ff, long_in;
   logic        store;
   logic        is_digit, is_space;
   logic [15:0] num_x10;
   logic [7:0]  mem [MAX_LINE_LEN];
   logic [7:0]  rd_data_ff;

   assign is_digit = (ch >= sltpt_pkg::CH_ZERO) && (ch <= sltpt_pkg::CH_NINE);
   assign is_space = (ch == sltpt_pkg::CH_SPACE);
   assign num_x10  = {num_ff[12:0], 3'b000} + {num_ff[14:0], 1'b0};

   always_comb begin
      phase_in = phase_ff;
      num_in   = num_ff;
      len_in   = len_ff;
      long_in  = long_ff;
      store    = 1'b0;
      reject   = 1'b0;
      if (char_we && (ch != sltpt_pkg::CH_NUL)) begin
         if ((phase_ff == PH_DIGITS) && is_digit) begin
            num_in = num_x10 + 16'(ch - sltpt_pkg::CH_ZERO);
         end else if ((phase_ff != PH_TEXT) && is_space) begin
            phase_in = PH_SKIP;
         end else begin
            phase_in = PH_TEXT;
            if (len_ff < LW'(MAX_LINE_LEN)) begin
               store  = 1'b1;
               len_in = len_ff + 1'b1;
            end else begin
               long_in = 1'b1;
               reject  = 1'b1;
            end
         end
      end
      if (clear) begin
         phase_in = PH_DIGITS;
         num_in   = '0;
         len_in   = '0;
         long_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DIGITS;
         num_ff   <= '0;
         len_ff   <= '0;
         long_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         len_ff   <= len_in;
         long_ff  <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem[len_ff[LAW-1:0]] <= ch;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data       = rd_data_ff;
   assign info.number   = num_ff;
   assign info.length   = sltpt_pkg::LEN_W'(len_ff);
   assign info.too_long = long_ff;

endmodule

`default_nettype wire

### sv/sorted_line_table_with_packed_text.sv
// ----------------------------------------------------------------------------
// sorted_line_table_with_packed_text
// Line table sorted by number, with line text packed downward in a byte store.
//
//   Channel  Direction  Handshake             Content
//   req_     in         req_valid/req_stall   type, character, number, index
//   rsp_     out        rsp_valid/rsp_stall   status, counts, find and read data
//
// A character transaction goes straight from idle to the response state. Find
// and commit run a binary search, a read state and a compare state per step,
// through the entry memory read port, then a lookup of the entry and the
// next one. A commit then moves text one byte per cycle, copies the new text
// one byte per cycle and sweeps the affected entries one per cycle. Reset is
// synchronous and clears the line count, free space and parser; the memories
// are not cleared. A stalled response holds the block in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_line_table_with_packed_text #(
   parameter int MAX_LINES    = sltpt_pkg::MAX_LINES_DEF,
   parameter int STORE_BYTES  = sltpt_pkg::STORE_BYTES_DEF,
   parameter int MAX_LINE_LEN = sltpt_pkg::MAX_LINE_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_ch,
   input  wire logic [15:0] req_line_number,
   input  wire logic [9:0]  req_entry_index,
   input  wire logic [7:0]  req_byte_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [10:0]      rsp_line_count,
   output logic [10:0]      rsp_position,
   output logic             rsp_exact,
   output logic [7:0]       rsp_data_byte,
   output logic [8:0]       rsp_text_length,
   output logic [15:0]      rsp_stored_number,
   output logic [14:0]      rsp_free_bytes
);

   localparam int NW  = $clog2(MAX_LINES + 1);
   localparam int IW  = $clog2(MAX_LINES);
   localparam int SW  = $clog2(STORE_BYTES + 1);
   localparam int AW  = $clog2(STORE_BYTES);
   localparam int LW  = $clog2(MAX_LINE_LEN + 1);
   localparam int LAW = $clog2(MAX_LINE_LEN);
   localparam int DW  = ((SW > LW) ? SW : LW) + 1;
   localparam int XW  = (NW > 10) ? NW : 10;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_SRCH   = 15'b000000000000010,
      S_SCMP   = 15'b000000000000100,
      S_LK0    = 15'b000000000001000,
      S_LK1    = 15'b000000000010000,
      S_LK2    = 15'b000000000100000,
      S_DECIDE = 15'b000000001000000,
      S_TRD    = 15'b000000010000000,
      S_TWAIT  = 15'b000000100000000,
      S_MOVE   = 15'b000001000000000,
      S_COPY   = 15'b000010000000000,
      S_OFFS   = 15'b000100000000000,
      S_SHIFT  = 15'b001000000000000,
      S_SETP   = 15'b010000000000000,
      S_RESP   = 15'b100000000000000
   } state_type;

   typedef enum logic [1:0] {
      EW_ADJ    = 2'd0,
      EW_COPY   = 2'd1,
      EW_DIRECT = 2'd2
   } ew_mode_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] key_ff, key_in;
   logic [NW-1:0] pos_ff, pos_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [7:0]  boff_ff, boff_in;
   logic [15:0] pnum_ff, pnum_in;
   logic [SW-1:0] poff_ff, poff_in, nxt_ff, nxt_in;
   logic [NW-1:0] count_ff, count_in;
   logic [SW-1:0] free_ff, free_in;
   logic [2:0]  status_ff, status_in;
   logic [NW-1:0] rpos_ff, rpos_in;
   logic        rexact_ff, rexact_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [DW-1:0] rtlen_ff, rtlen_in;
   logic [15:0] rsnum_ff, rsnum_in;
   logic [DW-1:0] shift_ff, shift_in, mv_cnt_ff, mv_cnt_in, mv_addr_ff, mv_addr_in;
   logic        mv_up_ff, mv_up_in;
   logic [DW-1:0] cp_cnt_ff, cp_cnt_in, cp_k_ff, cp_k_in, cp_dst_ff, cp_dst_in;
   logic [NW-1:0] ofs_cnt_ff, ofs_cnt_in, ofs_addr_ff, ofs_addr_in;
   logic [NW-1:0] sh_cnt_ff, sh_cnt_in, sh_addr_ff, sh_addr_in;
   logic        sh_del_ff, sh_del_in;
   logic        setp_ff, setp_in;
   logic [DW-1:0] setp_off_ff, setp_off_in;
   logic        tw_valid_ff, tw_valid_in, tw_pend_ff, tw_pend_in;
   logic [AW-1:0] tw_addr_ff, tw_addr_in;
   logic        ew_valid_ff, ew_valid_in;
   logic [IW-1:0] ew_addr_ff, ew_addr_in;
   ew_mode_type ew_mode_ff, ew_mode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [10:0] rsp_line_count_ff, rsp_position_ff;
   logic        rsp_exact_ff;
   logic [7:0]  rsp_data_byte_ff;
   logic [8:0]  rsp_text_length_ff;
   logic [15:0] rsp_stored_number_ff;
   logic [14:0] rsp_free_bytes_ff;
   logic        rsp_load;

   logic [15:0]   ent_num [MAX_LINES];
   logic [SW-1:0] ent_off [MAX_LINES];
   logic [15:0]   e_rd_num_ff;
   logic [SW-1:0] e_rd_off_ff;
   logic [IW-1:0] e_raddr;
   logic [15:0]   ew_num;
   logic [SW-1:0] ew_off;

   logic [AW-1:0] t_raddr;
   logic [7:0]    t_rdata, t_wdata, lb_rd_data;
   logic [LAW-1:0] lb_rd_addr;
   logic          lb_char_we, lb_clear, lb_reject;
   sltpt_pkg::pend_info_type lb_info;

   logic          in_tab, nxt_in_tab, found;
   logic [DW-1:0] e0, e1, tend, tbeg, old_len, new_len, free_dw;
   logic [NW:0]   mid_sum;

   sltpt_line_buf #(
      .MAX_LINE_LEN(MAX_LINE_LEN)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .char_we (lb_char_we),
      .ch      (req_ch),
      .clear   (lb_clear),
      .rd_addr (lb_rd_addr),
      .rd_data (lb_rd_data),
      .info    (lb_info),
      .reject  (lb_reject)
   );

   sltpt_text_mem #(
      .DEPTH(STORE_BYTES)
   ) u_text_mem (
      .clock (clock),
      .we    (tw_valid_ff),
      .waddr (tw_addr_ff),
      .wdata (t_wdata),
      .raddr (t_raddr),
      .rdata (t_rdata)
   );

   assign t_wdata = tw_pend_ff ? lb_rd_data : t_rdata;

   always_comb begin
      unique case (ew_mode_ff)
         EW_ADJ: begin
            ew_num = e_rd_num_ff;
            ew_off = SW'(DW'(e_rd_off_ff) + shift_ff);
         end
         EW_COPY: begin
            ew_num = e_rd_num_ff;
            ew_off = e_rd_off_ff;
         end
         EW_DIRECT: begin
            ew_num = key_ff;
            ew_off = SW'(setp_off_ff);
         end
         default: begin
            ew_num = e_rd_num_ff;
            ew_off = e_rd_off_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ew_valid_ff) begin
         ent_num[ew_addr_ff] <= ew_num;
         ent_off[ew_addr_ff] <= ew_off;
      end
      e_rd_num_ff <= ent_num[e_raddr];
      e_rd_off_ff <= ent_off[e_raddr];
   end

   assign in_tab     = pos_ff < count_ff;
   assign nxt_in_tab = ((NW + 1)'(pos_ff) + 1'b1) < (NW + 1)'(count_ff);
   assign e0         = in_tab ? DW'(poff_ff) : DW'(STORE_BYTES);
   assign e1         = nxt_in_tab ? DW'(nxt_ff) : DW'(STORE_BYTES);
   assign found      = in_tab && (pnum_ff == key_ff);
   assign tend       = found ? e1 : e0;
   assign tbeg       = found ? DW'(poff_ff) : e0;
   assign old_len    = tend - tbeg;
   assign new_len    = DW'(lb_info.length);
   assign free_dw    = DW'(free_ff);
   assign mid_sum    = (NW + 1)'(lo_ff) + (NW + 1)'(hi_ff);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      boff_in     = boff_ff;
      pnum_in     = pnum_ff;
      poff_in     = poff_ff;
      nxt_in      = nxt_ff;
      count_in    = count_ff;
      free_in     = free_ff;
      status_in   = status_ff;
      rpos_in     = rpos_ff;
      rexact_in   = rexact_ff;
      rdata_in    = rdata_ff;
      rtlen_in    = rtlen_ff;
      rsnum_in    = rsnum_ff;
      shift_in    = shift_ff;
      mv_cnt_in   = mv_cnt_ff;
      mv_addr_in  = mv_addr_ff;
      mv_up_in    = mv_up_ff;
      cp_cnt_in   = cp_cnt_ff;
      cp_k_in     = cp_k_ff;
      cp_dst_in   = cp_dst_ff;
      ofs_cnt_in  = ofs_cnt_ff;
      ofs_addr_in = ofs_addr_ff;
      sh_cnt_in   = sh_cnt_ff;
      sh_addr_in  = sh_addr_ff;
      sh_del_in   = sh_del_ff;
      setp_in     = setp_ff;
      setp_off_in = setp_off_ff;
      tw_valid_in = 1'b0;
      tw_addr_in  = tw_addr_ff;
      tw_pend_in  = tw_pend_ff;
      ew_valid_in = 1'b0;
      ew_addr_in  = ew_addr_ff;
      ew_mode_in  = ew_mode_ff;
      e_raddr     = '0;
      t_raddr     = '0;
      lb_rd_addr  = '0;
      lb_char_we  = 1'b0;
      lb_clear    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_type;
               status_in = sltpt_pkg::ST_OK;
               rpos_in   = '0;
               rexact_in = 1'b0;
               rdata_in  = '0;
               rtlen_in  = '0;
               rsnum_in  = '0;
               unique case (req_type)
                  sltpt_pkg::REQ_CHAR: begin
                     lb_char_we = 1'b1;
                     status_in  = lb_reject ? sltpt_pkg::ST_TOO_LONG : sltpt_pkg::ST_OK;
                     state_in   = S_RESP;
                  end
                  sltpt_pkg::REQ_COMMIT: begin
                     if (lb_info.too_long) begin
                        status_in = sltpt_pkg::ST_TOO_LONG;
                        state_in  = S_RESP;
                     end else if (lb_info.number == sltpt_pkg::RESERVED_NUMBER) begin
                        status_in = sltpt_pkg::ST_RESERVED;
                        state_in  = S_RESP;
                     end else begin
                        key_in   = lb_info.number;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = S_SRCH;
                     end
                  end
                  sltpt_pkg::REQ_FIND: begin
                     key_in   = req_line_number;
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_SRCH;
                  end
                  default: begin
                     boff_in = req_byte_offset;
                     if (XW'(req_entry_index) < XW'(count_ff)) begin
                        pos_in   = NW'(req_entry_index);
                        state_in = S_LK0;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff == hi_ff) begin
               pos_in   = lo_ff;
               state_in = S_LK0;
            end else begin
               mid_in   = IW'(mid_sum >> 1);
               e_raddr  = IW'(mid_sum >> 1);
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (e_rd_num_ff < key_ff) begin
               lo_in = NW'(mid_ff) + 1'b1;
            end else begin
               hi_in = NW'(mid_ff);
            end
            state_in = S_SRCH;
         end
         S_LK0: begin
            e_raddr  = IW'(pos_ff);
            state_in = S_LK1;
         end
         S_LK1: begin
            pnum_in  = e_rd_num_ff;
            poff_in  = e_rd_off_ff;
            e_raddr  = IW'(pos_ff + 1'b1);
            state_in = S_LK2;
         end
         S_LK2: begin
            nxt_in   = e_rd_off_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (op_ff == sltpt_pkg::REQ_FIND) begin
               rpos_in   = pos_ff;
               rexact_in = found;
            end else if (op_ff == sltpt_pkg::REQ_READ) begin
               rtlen_in = e1 - DW'(poff_ff);
               rsnum_in = pnum_ff;
               if (DW'(boff_ff) < (e1 - DW'(poff_ff))) begin
                  state_in = S_TRD;
               end
            end else begin
               shift_in    = old_len - new_len;
               mv_cnt_in   = tbeg - free_dw;
               mv_up_in    = old_len > new_len;
               mv_addr_in  = (old_len > new_len) ? (tbeg - 1'b1) : free_dw;
               cp_cnt_in   = new_len;
               cp_k_in     = '0;
               cp_dst_in   = tend - new_len;
               ofs_cnt_in  = (old_len != new_len) ? pos_ff : '0;
               ofs_addr_in = '0;
               setp_in     = (new_len != '0);
               setp_off_in = tend - new_len;
               free_in     = SW'(free_dw + old_len - new_len);
               if (found) begin
                  if (new_len == '0) begin
                     sh_del_in  = 1'b1;
                     sh_cnt_in  = count_ff - pos_ff - 1'b1;
                     sh_addr_in = pos_ff + 1'b1;
                     count_in   = count_ff - 1'b1;
                     state_in   = S_MOVE;
                  end else if (new_len > (free_dw + old_len)) begin
                     status_in = sltpt_pkg::ST_STORE_FULL;
                     free_in   = free_ff;
                  end else begin
                     sh_del_in = 1'b0;
                     sh_cnt_in = '0;
                     state_in  = S_MOVE;
                  end
               end else begin
                  free_in = free_ff;
                  if (new_len == '0) begin
                     status_in = sltpt_pkg::ST_OK;
                  end else if (count_ff >= NW'(MAX_LINES)) begin
                     status_in = sltpt_pkg::ST_TABLE_FULL;
                  end else if (new_len > free_dw) begin
                     status_in = sltpt_pkg::ST_STORE_FULL;
                  end else begin
                     sh_del_in  = 1'b0;
                     sh_cnt_in  = count_ff - pos_ff;
                     sh_addr_in = count_ff - 1'b1;
                     count_in   = count_ff + 1'b1;
                     free_in    = SW'(free_dw - new_len);
                     state_in   = S_MOVE;
                  end
               end
            end
         end
         S_TRD: begin
            t_raddr  = AW'(DW'(poff_ff) + DW'(boff_ff));
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            rdata_in = t_rdata;
            state_in = S_RESP;
         end
         S_MOVE: begin
            if ((mv_cnt_ff == '0) || (shift_ff == '0)) begin
               state_in = S_COPY;
            end else begin
               t_raddr     = AW'(mv_addr_ff);
               tw_valid_in = 1'b1;
               tw_addr_in  = AW'(mv_addr_ff + shift_ff);
               tw_pend_in  = 1'b0;
               mv_addr_in  = mv_up_ff ? (mv_addr_ff - 1'b1) : (mv_addr_ff + 1'b1);
               mv_cnt_in   = mv_cnt_ff - 1'b1;
               if (mv_cnt_ff == DW'(1)) begin
                  state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            if (cp_cnt_ff == '0) begin
               state_in = S_OFFS;
            end else begin
               lb_rd_addr  = cp_k_ff[LAW-1:0];
               tw_valid_in = 1'b1;
               tw_addr_in  = AW'(cp_dst_ff + cp_k_ff);
               tw_pend_in  = 1'b1;
               cp_k_in     = cp_k_ff + 1'b1;
               cp_cnt_in   = cp_cnt_ff - 1'b1;
               if (cp_cnt_ff == DW'(1)) begin
                  state_in = S_OFFS;
               end
            end
         end
         S_OFFS: begin
            if (ofs_cnt_ff == '0) begin
               state_in = S_SHIFT;
            end else begin
               e_raddr     = IW'(ofs_addr_ff);
               ew_valid_in = 1'b1;
               ew_addr_in  = IW'(ofs_addr_ff);
               ew_mode_in  = EW_ADJ;
               ofs_addr_in = ofs_addr_ff + 1'b1;
               ofs_cnt_in  = ofs_cnt_ff - 1'b1;
               if (ofs_cnt_ff == NW'(1)) begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (sh_cnt_ff == '0) begin
               state_in = S_SETP;
            end else begin
               e_raddr     = IW'(sh_addr_ff);
               ew_valid_in = 1'b1;
               ew_addr_in  = sh_del_ff ? IW'(sh_addr_ff - 1'b1) : IW'(sh_addr_ff + 1'b1);
               ew_mode_in  = EW_COPY;
               sh_addr_in  = sh_del_ff ? (sh_addr_ff + 1'b1) : (sh_addr_ff - 1'b1);
               sh_cnt_in   = sh_cnt_ff - 1'b1;
               if (sh_cnt_ff == NW'(1)) begin
                  state_in = S_SETP;
               end
            end
         end
         S_SETP: begin
            if (setp_ff) begin
               ew_valid_in = 1'b1;
               ew_addr_in  = IW'(pos_ff);
               ew_mode_in  = EW_DIRECT;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               lb_clear     = (op_ff == sltpt_pkg::REQ_COMMIT);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         free_ff      <= SW'(STORE_BYTES);
         tw_valid_ff  <= 1'b0;
         ew_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         tw_valid_ff  <= tw_valid_in;
         ew_valid_ff  <= ew_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      boff_ff     <= boff_in;
      pnum_ff     <= pnum_in;
      poff_ff     <= poff_in;
      nxt_ff      <= nxt_in;
      status_ff   <= status_in;
      rpos_ff     <= rpos_in;
      rexact_ff   <= rexact_in;
      rdata_ff    <= rdata_in;
      rtlen_ff    <= rtlen_in;
      rsnum_ff    <= rsnum_in;
      shift_ff    <= shift_in;
      mv_cnt_ff   <= mv_cnt_in;
      mv_addr_ff  <= mv_addr_in;
      mv_up_ff    <= mv_up_in;
      cp_cnt_ff   <= cp_cnt_in;
      cp_k_ff     <= cp_k_in;
      cp_dst_ff   <= cp_dst_in;
      ofs_cnt_ff  <= ofs_cnt_in;
      ofs_addr_ff <= ofs_addr_in;
      sh_cnt_ff   <= sh_cnt_in;
      sh_addr_ff  <= sh_addr_in;
      sh_del_ff   <= sh_del_in;
      setp_ff     <= setp_in;
      setp_off_ff <= setp_off_in;
      tw_addr_ff  <= tw_addr_in;
      tw_pend_ff  <= tw_pend_in;
      ew_addr_ff  <= ew_addr_in;
      ew_mode_ff  <= ew_mode_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_line_count_ff    <= 11'(count_ff);
         rsp_position_ff      <= 11'(rpos_ff);
         rsp_exact_ff         <= rexact_ff;
         rsp_data_byte_ff     <= rdata_ff;
         rsp_text_length_ff   <= 9'(rtlen_ff);
         rsp_stored_number_ff <= rsnum_ff;
         rsp_free_bytes_ff    <= 15'(free_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_line_count    = rsp_line_count_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_exact         = rsp_exact_ff;
   assign rsp_data_byte     = rsp_data_byte_ff;
   assign rsp_text_length   = rsp_text_length_ff;
   assign rsp_stored_number = rsp_stored_number_ff;
   assign rsp_free_bytes    = rsp_free_bytes_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_LINES))
      else $error("line count above table size");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= SW'(STORE_BYTES))
      else $error("free byte count above store size");

   a_text_write_src: assert property (@(posedge clock) disable iff (reset)
      tw_valid_ff |-> ($past(state_ff) == S_MOVE || $past(state_ff) == S_COPY))
      else $error("text write outside move or copy");

   a_entry_write_src: assert property (@(posedge clock) disable iff (reset)
      ew_valid_ff |-> ($past(state_ff) == S_OFFS || $past(state_ff) == S_SHIFT ||
                       $past(state_ff) == S_SETP))
      else $error("entry write outside table update");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP && state_ff == S_IDLE))
      else $error("response raised outside final state");
`endif

endmodule

`default_nettype wire
